[src/assert_macros.svh]
// Assertion macros used by the checker file of the cipher unit.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert that the antecedent implies the consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

[src/cvc_pkg.sv]
// Shared types, status codes and letter lookup functions for the cipher unit.
// No dependencies.
package cvc_pkg;

  localparam int unsigned ALPHA_SIZE = 33;

  // result status codes
  localparam logic [2:0] ST_LETTER     = 3'd0;
  localparam logic [2:0] ST_KEY_STORED = 3'd1;
  localparam logic [2:0] ST_SKIPPED    = 3'd2;
  localparam logic [2:0] ST_BAD_KEY    = 3'd3;
  localparam logic [2:0] ST_BAD_CIPHER = 3'd4;
  localparam logic [2:0] ST_NO_KEY     = 3'd5;
  localparam logic [2:0] ST_EMPTY_TEXT = 3'd6;

  localparam logic REQ_KEY  = 1'b0;
  localparam logic REQ_TEXT = 1'b1;

  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  localparam logic [15:0] CP_YO_UP    = 16'h0401;
  localparam logic [15:0] CP_A_UP     = 16'h0410;
  localparam logic [15:0] CP_IE_UP    = 16'h0415;
  localparam logic [15:0] CP_ZHE_UP   = 16'h0416;
  localparam logic [15:0] CP_YA_UP    = 16'h042F;
  localparam logic [15:0] CP_A_LO     = 16'h0430;
  localparam logic [15:0] CP_YA_LO    = 16'h044F;
  localparam logic [15:0] CP_YO_LO    = 16'h0451;
  localparam logic [15:0] CASE_OFFSET = 16'h0020;
  localparam logic [5:0]  IDX_YO      = 6'd6;

  // one item on its way from the key control stage to the cipher stage
  typedef struct packed {
    logic [2:0] status;
    logic [5:0] text_idx;
    logic       decrypt;
    logic       last;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] idx;
  } lookup_t;

  function automatic lookup_t upper_index(input logic [15:0] cp);
    lookup_t r;
    r = '0;
    if (cp == CP_YO_UP) begin
      r = '{valid: 1'b1, idx: IDX_YO};
    end else if (cp >= CP_A_UP && cp <= CP_IE_UP) begin
      r = '{valid: 1'b1, idx: 6'(cp - CP_A_UP)};
    end else if (cp >= CP_ZHE_UP && cp <= CP_YA_UP) begin
      r = '{valid: 1'b1, idx: 6'(cp - CP_ZHE_UP) + IDX_YO + 6'd1};
    end
    return r;
  endfunction

  function automatic lookup_t any_index(input logic [15:0] cp);
    lookup_t r;
    if (cp == CP_YO_LO) begin
      r = '{valid: 1'b1, idx: IDX_YO};
    end else if (cp >= CP_A_LO && cp <= CP_YA_LO) begin
      r = upper_index(cp - CASE_OFFSET);
    end else begin
      r = upper_index(cp);
    end
    return r;
  endfunction

  function automatic logic [10:0] idx_to_cp(input logic [5:0] idx);
    logic [10:0] r;
    if (idx == IDX_YO) begin
      r = 11'(CP_YO_UP);
    end else if (idx < IDX_YO) begin
      r = 11'(CP_A_UP) + 11'(idx);
    end else begin
      r = 11'(CP_ZHE_UP) + 11'(idx) - 11'(IDX_YO) - 11'd1;
    end
    return r;
  endfunction

endpackage

[src/cvc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cvc_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/cvc_key_ctrl.sv]
// Front stage: decodes each item, keeps key length and message position, and
// drives the key store write and read ports. Depends on cvc_pkg.
module cvc_key_ctrl #(
  parameter int unsigned KEY_MAX = 64
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           accept,
  input  logic                                           req_type,
  input  logic [15:0]                                    code_point,
  input  logic                                           first_of_run,
  input  logic                                           last_of_run,
  input  logic                                           cipher_mode,
  output logic                                           key_we,
  output logic [(KEY_MAX > 1 ? $clog2(KEY_MAX) : 1)-1:0] key_waddr,
  output logic [5:0]                                     key_wdata,
  output logic                                           key_re,
  output logic [(KEY_MAX > 1 ? $clog2(KEY_MAX) : 1)-1:0] key_raddr,
  output cvc_pkg::item_t                                 item
);
  import cvc_pkg::*;

  localparam int unsigned ADDR_W = KEY_MAX > 1 ? $clog2(KEY_MAX) : 1;
  localparam int unsigned LEN_W  = $clog2(KEY_MAX + 1);

  logic [LEN_W-1:0]  key_len_r, key_len_nxt;
  logic              key_inv_r, key_inv_nxt;
  logic [ADDR_W-1:0] key_pos_r, key_pos_nxt;
  logic              seen_r, seen_nxt;

  logic [LEN_W-1:0]  len0, pos_use, pos_inc;
  logic [ADDR_W-1:0] pos0;
  logic              inv0, seen0;
  lookup_t           key_lk, txt_lk;

  always_comb begin
    key_len_nxt = key_len_r;
    key_inv_nxt = key_inv_r;
    key_pos_nxt = key_pos_r;
    seen_nxt    = seen_r;
    key_we      = 1'b0;
    key_re      = 1'b0;
    item        = '0;
    item.decrypt = cipher_mode;

    len0    = first_of_run ? '0 : key_len_r;
    inv0    = first_of_run ? 1'b0 : key_inv_r;
    pos0    = first_of_run ? '0 : key_pos_r;
    seen0   = first_of_run ? 1'b0 : seen_r;
    key_lk  = any_index(code_point);
    txt_lk  = (cipher_mode == MODE_DECRYPT) ? upper_index(code_point) : key_lk;
    // wrap a position left past the end by a shortened key
    pos_use = (LEN_W'(pos0) >= key_len_r) ? '0 : LEN_W'(pos0);
    pos_inc = pos_use + LEN_W'(1);

    key_waddr   = len0[ADDR_W-1:0];
    key_wdata   = key_lk.idx;
    key_raddr   = pos_use[ADDR_W-1:0];
    item.text_idx = txt_lk.idx;

    if (req_type == REQ_KEY) begin
      key_len_nxt = len0;
      key_inv_nxt = inv0;
      if (inv0 || !key_lk.valid) begin
        key_inv_nxt = 1'b1;
        item.status = ST_BAD_KEY;
      end else begin
        item.status = ST_KEY_STORED;
        // drop letters past a full store
        if (len0 < LEN_W'(KEY_MAX)) begin
          key_we      = accept;
          key_len_nxt = len0 + LEN_W'(1);
        end
      end
    end else begin
      item.last   = last_of_run;
      key_pos_nxt = pos0;
      seen_nxt    = seen0;
      if (key_len_r == '0 || key_inv_r) begin
        item.status = ST_NO_KEY;
      end else if (!txt_lk.valid) begin
        if (cipher_mode == MODE_DECRYPT) begin
          item.status = ST_BAD_CIPHER;
        end else begin
          item.status = (last_of_run && !seen0) ? ST_EMPTY_TEXT : ST_SKIPPED;
        end
      end else begin
        item.status = ST_LETTER;
        key_re      = accept;
        key_pos_nxt = (pos_inc >= key_len_r) ? '0 : pos_inc[ADDR_W-1:0];
        seen_nxt    = 1'b1;
      end
      if (last_of_run) begin
        key_pos_nxt = '0;
        seen_nxt    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= '0;
      key_inv_r <= 1'b0;
      key_pos_r <= '0;
      seen_r    <= 1'b0;
    end else if (accept) begin
      key_len_r <= key_len_nxt;
      key_inv_r <= key_inv_nxt;
      key_pos_r <= key_pos_nxt;
      seen_r    <= seen_nxt;
    end
  end

endmodule

[src/cvc_cipher_stage.sv]
// Back stages: hold each item while the key letter is read, apply the modulo-33
// shift and hold the result in the output register. Depends on cvc_pkg.
module cvc_cipher_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  cvc_pkg::item_t item,
  input  logic [5:0]     key_letter,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     out_status,
  output logic [5:0]     out_letter_index,
  output logic [10:0]    out_cp,
  output logic           out_last
);
  import cvc_pkg::*;

  logic        s1_valid_r;
  item_t       s1_item_r;
  logic        out_valid_r;
  logic [2:0]  status_r;
  logic [5:0]  idx_r;
  logic [10:0] cp_r;
  logic        last_r;
  logic        s1_go;
  logic [6:0]  sum, wrapped;
  logic [5:0]  idx_nxt;

  assign s1_go    = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_go;

  always_comb begin
    if (s1_item_r.decrypt == MODE_DECRYPT) begin
      sum = {1'b0, s1_item_r.text_idx} + 7'(ALPHA_SIZE) - {1'b0, key_letter};
    end else begin
      sum = {1'b0, s1_item_r.text_idx} + {1'b0, key_letter};
    end
    wrapped = (sum >= 7'(ALPHA_SIZE)) ? sum - 7'(ALPHA_SIZE) : sum;
    idx_nxt = (s1_item_r.status == ST_LETTER) ? wrapped[5:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= accept;
      end
      if (s1_go) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= item;
    end
    if (s1_go && s1_valid_r) begin
      status_r <= s1_item_r.status;
      idx_r    <= idx_nxt;
      cp_r     <= (s1_item_r.status == ST_LETTER) ? idx_to_cp(idx_nxt) : '0;
      last_r   <= s1_item_r.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_letter_index = idx_r;
  assign out_cp           = cp_r;
  assign out_last         = last_r;

endmodule

[src/cyrillic_vigenere_cipher_unit.sv]
// Vigenere cipher over the 33-letter Russian alphabet, one code point per
// transfer. Takes one item every cycle unless the output stalls, and returns
// one result per item through an item register, set beside the key store's
// registered read, and the output register. Key position bookkeeping updates
// at transfer so consecutive letters need no interlock. Key items (tuser bit 0
// low) append a letter, tuser bit 1 restarts the key or the message; cfg_wdata
// selects encrypt (0) or decrypt (1) and must be written only while no item is
// in flight. Depends on cvc_pkg, cvc_ram, cvc_key_ctrl and cvc_cipher_stage.
module cyrillic_vigenere_cipher_unit #(
  parameter int unsigned KEY_MAX = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,    // cipher_mode
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // [15:0] code_point
  input  logic [1:0]  in_tuser,     // [0] req_type, [1] first_of_run
  input  logic        in_tlast,     // last_of_run
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,    // [2:0] status, [8:3] letter_index,
                                    // [19:9] out_code_point, [23:20] zero
  output logic        out_tlast     // end_of_message
);
  import cvc_pkg::*;

  localparam int unsigned ADDR_W = KEY_MAX > 1 ? $clog2(KEY_MAX) : 1;

  logic              mode_r;
  logic              accept;
  logic              key_we, key_re;
  logic [ADDR_W-1:0] key_waddr, key_raddr;
  logic [5:0]        key_wdata, key_rdata;
  item_t             item;
  logic [2:0]        status;
  logic [5:0]        letter_index;
  logic [10:0]       cp;

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ENCRYPT;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  cvc_key_ctrl #(.KEY_MAX(KEY_MAX)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .req_type     (in_tuser[0]),
    .code_point   (in_tdata),
    .first_of_run (in_tuser[1]),
    .last_of_run  (in_tlast),
    .cipher_mode  (mode_r),
    .key_we       (key_we),
    .key_waddr    (key_waddr),
    .key_wdata    (key_wdata),
    .key_re       (key_re),
    .key_raddr    (key_raddr),
    .item         (item)
  );

  cvc_ram #(.WIDTH(6), .DEPTH(KEY_MAX)) u_key_store (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .re    (key_re),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  cvc_cipher_stage u_cipher (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .item             (item),
    .key_letter       (key_rdata),
    .in_ready         (in_tready),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_status       (status),
    .out_letter_index (letter_index),
    .out_cp           (cp),
    .out_last         (out_tlast)
  );

  assign out_tdata = {4'd0, cp, letter_index, status};

endmodule

[src/cvc_checker.sv]
// Port-level checks for the cipher unit, bound to the top level.
// Depends on cvc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cvc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);
  import cvc_pkg::*;

  logic [2:0]  status;
  logic [5:0]  letter_index;
  logic [10:0] cp;

  assign status       = out_tdata[2:0];
  assign letter_index = out_tdata[8:3];
  assign cp           = out_tdata[19:9];

  `ASSERT_IMPL(a_status_range, out_tvalid, status <= ST_EMPTY_TEXT, "status code out of range")
  `ASSERT_IMPL(a_no_letter_zero, out_tvalid && status != ST_LETTER, letter_index == '0 && cp == '0, "letter fields set on non-letter result")
  `ASSERT_IMPL(a_letter_matches, out_tvalid && status == ST_LETTER, letter_index < 6'(ALPHA_SIZE) && cp == idx_to_cp(letter_index), "letter index and code point disagree")
  `ASSERT_IMPL(a_key_not_last, out_tvalid && (status == ST_KEY_STORED || status == ST_BAD_KEY), !out_tlast, "key result marked end of message")
  `ASSERT_CLK(a_stall_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")

endmodule

bind cyrillic_vigenere_cipher_unit cvc_checker u_cvc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
